[design/lpcc_pkg.sv]
// Package for the line printer column canonicalizer.
// Holds the word types, function codes, character codes and register defaults.
// No dependencies.
`default_nettype none
package lpcc_pkg;

    typedef enum logic [1:0] {
        FUNC_CHAR  = 2'd0,
        FUNC_OPEN  = 2'd1,
        FUNC_CLOSE = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_FILL    = 2'd1,
        CFG_LINES   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_func      func;
        logic [7:0] char_in;
        logic       auto_eject;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic [7:0] repeat_res;
        logic       open_error;
        logic       last;
    } t_out_word;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [8:0] TAB_STEP = 9'd8;

    localparam logic [7:0] DEF_COLUMNS = 8'd132;
    localparam logic [7:0] DEF_FILL    = 8'd96;
    localparam logic [7:0] DEF_LINES   = 8'd60;

endpackage
`default_nettype wire

[design/line_printer_column_canonicalizer.sv]
// Line printer column canonicalizer: input word register, one pass of column logic,
// and a three-entry result holder, unloaded one word per cycle when not stalled.
// Depends on lpcc_pkg.
// Results of a word pass through the input register, then the result holder.
// Throughput: one word per cycle while each yields at most one result and no stall;
// more results hold the next word until the last one leaves the single holder.
// Reset (synchronous, active low): registers to 132/96/60, state cleared, empty.
`default_nettype none
module line_printer_column_canonicalizer
    import lpcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_word   i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_word       o_out
);

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

    // configuration
    logic [7:0] r_cols, r_fill, r_lpp;
    logic [7:0] n_cols;

    // printer state
    logic [7:0] r_lcol, r_head, r_lc;
    logic       r_top, r_open, r_eject;
    logic [7:0] n_lcol, n_head, n_lc;
    logic       n_top, n_open, n_eject;

    // input register
    t_in_word r_in;
    logic     r_in_valid;

    // result holder
    t_out_word r_res [3];
    logic [1:0] r_left, r_pos;

    t_out_word  res [3];
    logic [1:0] cnt;
    logic       in_take, out_take, holder_free, proc;

    // combinational work for one word
    logic       do_le, le_nlff, is_print;
    logic [7:0] le_ch, lc1, le_out, h;
    logic [8:0] tab_t;
    logic [1:0] k;

    always_comb begin
        n_cols  = r_cols;
        n_lcol  = r_lcol;
        n_head  = r_head;
        n_lc    = r_lc;
        n_top   = r_top;
        n_open  = r_open;
        n_eject = r_eject;
        cnt     = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
        end
        do_le    = 1'b0;
        le_nlff  = 1'b0;
        le_ch    = CH_NL;
        is_print = 1'b0;
        tab_t    = '0;
        lc1      = '0;
        le_out   = '0;
        h        = r_head;
        k        = 2'd0;

        unique case (r_in.func)
            FUNC_CHAR: begin
                unique case (r_in.char_in)
                    CH_TAB: begin
                        tab_t  = ({1'b0, r_lcol} + TAB_STEP) & ~(TAB_STEP - 9'd1);
                        n_lcol = tab_t[8] ? 8'hFF : tab_t[7:0];
                    end
                    CH_FF, CH_NL, CH_CR: begin
                        do_le   = 1'b1;
                        le_nlff = (r_in.char_in != CH_CR);
                        le_ch   = r_in.char_in;
                    end
                    CH_BS: begin
                        if (r_lcol != 8'd0) begin
                            n_lcol = r_lcol - 8'd1;
                        end
                    end
                    CH_SP: begin
                        n_lcol = sat_inc(r_lcol);
                    end
                    default: begin
                        is_print = 1'b1;
                    end
                endcase
            end
            FUNC_OPEN: begin
                if (r_open) begin
                    res[0].open_error = 1'b1;
                    cnt = 2'd1;
                end else begin
                    n_open  = 1'b1;
                    n_eject = r_in.auto_eject;
                    n_top   = r_in.auto_eject;
                    n_lc    = 8'd0;
                    n_head  = 8'd0;
                    if (r_cols == 8'd0) begin
                        n_cols = DEF_COLUMNS;
                    end
                    // form feed at top of page prints nothing, only homes the column
                    if (r_in.auto_eject) begin
                        n_lcol = 8'd0;
                    end
                end
            end
            FUNC_CLOSE: begin
                do_le   = r_eject;
                le_nlff = 1'b1;
                le_ch   = CH_FF;
            end
            default: begin
            end
        endcase

        if (do_le) begin
            if (le_nlff && !r_top) begin
                lc1    = sat_inc(r_lc);
                le_out = (lc1 >= r_lpp && r_eject) ? CH_FF : le_ch;
                res[0].out_char   = le_out;
                res[0].repeat_res = 8'd1;
                cnt = 2'd1;
                if (r_fill >= 8'd2) begin
                    res[1].out_char   = CH_NUL;
                    res[1].repeat_res = r_fill - 8'd1;
                    cnt = 2'd2;
                end
                if (le_out == CH_FF) begin
                    n_lc  = 8'd0;
                    n_top = 1'b1;
                end else begin
                    n_lc  = lc1;
                    n_top = 1'b0;
                end
            end else if (r_head != 8'd0) begin
                res[0].out_char   = CH_CR;
                res[0].repeat_res = 8'd1;
                cnt   = 2'd1;
                n_top = 1'b0;
            end
            n_head = 8'd0;
            n_lcol = 8'd0;
        end

        if (r_in.func == FUNC_CLOSE) begin
            n_top   = 1'b0;
            n_open  = 1'b0;
            n_eject = 1'b0;
        end

        if (is_print) begin
            // return the head when the target column lies behind it
            if (r_lcol < h) begin
                res[k].out_char   = CH_CR;
                res[k].repeat_res = 8'd1;
                k = k + 2'd1;
                h = 8'd0;
            end
            if (r_lcol < r_cols) begin
                if (r_lcol > h) begin
                    res[k].out_char   = CH_SP;
                    res[k].repeat_res = r_lcol - h;
                    k = k + 2'd1;
                    h = r_lcol;
                end
                res[k].out_char   = r_in.char_in;
                res[k].repeat_res = 8'd1;
                k = k + 2'd1;
                h = sat_inc(h);
            end
            n_lcol = sat_inc(r_lcol);
            n_head = h;
            cnt    = k;
            if (k != 2'd0) begin
                n_top = 1'b0;
            end
        end

        // flag the final word of this item
        for (int i = 0; i < 3; i++) begin
            res[i].last = (2'(i) == cnt - 2'd1);
        end
    end

    assign out_take    = o_out_valid && !i_out_stall;
    assign holder_free = (r_left == 2'd0) || (r_left == 2'd1 && out_take);
    assign proc        = r_in_valid && (holder_free || cnt == 2'd0);
    assign o_in_stall  = r_in_valid && !proc;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_left != 2'd0);
    assign o_out       = r_res[r_pos];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols     <= DEF_COLUMNS;
            r_fill     <= DEF_FILL;
            r_lpp      <= DEF_LINES;
            r_lcol     <= '0;
            r_head     <= '0;
            r_lc       <= '0;
            r_top      <= 1'b0;
            r_open     <= 1'b0;
            r_eject    <= 1'b0;
            r_in_valid <= 1'b0;
            r_left     <= '0;
            r_pos      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COLUMNS: r_cols <= i_cfg_data;
                    CFG_FILL:    r_fill <= i_cfg_data;
                    CFG_LINES:   r_lpp  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end else if (proc) begin
                r_cols <= n_cols;
            end

            if (proc) begin
                r_lcol  <= n_lcol;
                r_head  <= n_head;
                r_lc    <= n_lc;
                r_top   <= n_top;
                r_open  <= n_open;
                r_eject <= n_eject;
            end

            r_in_valid <= in_take || (r_in_valid && !proc);

            if (proc && cnt != 2'd0) begin
                r_left <= cnt;
                r_pos  <= 2'd0;
            end else if (out_take) begin
                r_left <= r_left - 2'd1;
                r_pos  <= r_pos + 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        if (proc && cnt != 2'd0) begin
            for (int i = 0; i < 3; i++) begin
                r_res[i] <= res[i];
            end
        end
    end

endmodule
`default_nettype wire
